>>> rtl/assert_macros.svh
// Assertion macros shared by the compensation datapath modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define PTC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("%m: assertion failed");

// Clocked check that also holds through reset.
`define PTC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");

`endif

>>> rtl/ptc_pkg.sv
// Shared types and constants of the pressure/temperature compensation block.
package ptc_pkg;

    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CALIB    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_FLOOR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CEILING  = 3'd5;

    localparam logic signed [23:0] TEMP_FLOOR_RST   = -24'sd2621440;
    localparam logic signed [23:0] TEMP_CEILING_RST = 24'sd5570560;

    localparam logic [25:0] PRESS_MAX = 26'h3FFFFFF;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } ptc_in_t;

    typedef struct packed {
        logic [25:0]        pressure_out;
        logic signed [23:0] temperature_out;
    } ptc_out_t;

    // Clamped temperature plus raw pressure, handed to the pressure pipe.
    typedef struct packed {
        logic [23:0]        u;
        logic signed [23:0] t;
    } ptc_mid_t;

    typedef struct packed {
        logic [15:0]        t1;
        logic [15:0]        tc2;
        logic signed [7:0]  tc3;
        logic signed [15:0] p1;
        logic signed [15:0] p2;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic [15:0]        p5;
        logic [15:0]        p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
        logic signed [23:0] temp_floor;
        logic signed [23:0] temp_ceiling;
    } ptc_coef_t;

endpackage

>>> rtl/ptc_cfg.sv
// Calibration register file with coefficient unpacking.
module ptc_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output ptc_pkg::ptc_coef_t             coef
);
    import ptc_pkg::*;

    logic [39:0]        temp_calib_reg;
    logic [47:0]        press_a_reg;
    logic [47:0]        press_b_reg;
    logic [31:0]        press_c_reg;
    logic signed [23:0] floor_reg;
    logic signed [23:0] ceiling_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_calib_reg <= '0;
            press_a_reg    <= '0;
            press_b_reg    <= '0;
            press_c_reg    <= '0;
            floor_reg      <= TEMP_FLOOR_RST;
            ceiling_reg    <= TEMP_CEILING_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TEMP_CALIB:    temp_calib_reg <= cfg_wdata[39:0];
                REG_PRESS_CALIB_A: press_a_reg    <= cfg_wdata[47:0];
                REG_PRESS_CALIB_B: press_b_reg    <= cfg_wdata[47:0];
                REG_PRESS_CALIB_C: press_c_reg    <= cfg_wdata[31:0];
                REG_TEMP_FLOOR:    floor_reg      <= cfg_wdata[23:0];
                REG_TEMP_CEILING:  ceiling_reg    <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        coef.t1           = temp_calib_reg[15:0];
        coef.tc2          = temp_calib_reg[31:16];
        coef.tc3          = temp_calib_reg[39:32];
        coef.p1           = press_a_reg[15:0];
        coef.p2           = press_a_reg[31:16];
        coef.p3           = press_a_reg[39:32];
        coef.p4           = press_a_reg[47:40];
        coef.p5           = press_b_reg[15:0];
        coef.p6           = press_b_reg[31:16];
        coef.p7           = press_b_reg[39:32];
        coef.p8           = press_b_reg[47:40];
        coef.p9           = press_c_reg[15:0];
        coef.p10          = press_c_reg[23:16];
        coef.p11          = press_c_reg[31:24];
        coef.temp_floor   = floor_reg;
        coef.temp_ceiling = ceiling_reg;
    end

endmodule

>>> rtl/ptc_temp.sv
// Four-stage temperature linearisation and clamp pipeline.
module ptc_temp (
    input  logic               aclk,
    input  logic               aresetn,
    input  ptc_pkg::ptc_coef_t coef,
    input  logic               s_valid,
    output logic               s_ready,
    input  ptc_pkg::ptc_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ptc_pkg::ptc_mid_t  m_data
);
    import ptc_pkg::*;

    `include "assert_macros.svh"

    localparam int STAGES = 4;
    localparam logic signed [61:0] TEMP_ROUND = 62'sd2147483648;

    logic [STAGES-1:0] v_reg;
    logic [STAGES:0]   rdy;
    logic [23:0]       u_reg [STAGES];

    logic signed [25:0] d_reg, d_next;
    logic signed [42:0] m1_reg, m1_next;
    logic signed [51:0] dsq_reg, dsq_next;
    logic signed [29:0] traw_reg, traw_next;
    logic signed [23:0] t_reg, t_next;

    // A stage takes new data when empty or when the next one moves on.
    always_comb begin
        rdy[STAGES] = m_ready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    always_comb begin
        logic signed [61:0] m1_w;
        logic signed [61:0] sum_w;
        logic signed [29:0] lo_w;
        d_next   = $signed({2'b00, s_data.raw_temperature})
                 - $signed({2'b00, coef.t1, 8'h00});
        m1_next  = d_reg * $signed({1'b0, coef.tc2});
        dsq_next = d_reg * d_reg;
        m1_w     = m1_reg;
        sum_w    = (m1_w <<< 18) + dsq_reg * $signed(coef.tc3) + TEMP_ROUND;
        traw_next = $signed(sum_w[61:32]);
        // floor first, ceiling wins if the two cross
        lo_w = traw_reg;
        if (traw_reg < $signed(coef.temp_floor)) begin
            lo_w = $signed(coef.temp_floor);
        end
        if (lo_w > $signed(coef.temp_ceiling)) begin
            lo_w = $signed(coef.temp_ceiling);
        end
        t_next = lo_w[23:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            d_reg    <= d_next;
            u_reg[0] <= s_data.raw_pressure;
        end
        if (rdy[1]) begin
            m1_reg   <= m1_next;
            dsq_reg  <= dsq_next;
            u_reg[1] <= u_reg[0];
        end
        if (rdy[2]) begin
            traw_reg <= traw_next;
            u_reg[2] <= u_reg[1];
        end
        if (rdy[3]) begin
            t_reg    <= t_next;
            u_reg[3] <= u_reg[2];
        end
    end

    assign s_ready  = rdy[0];
    assign m_valid  = v_reg[STAGES-1];
    assign m_data.u = u_reg[STAGES-1];
    assign m_data.t = t_reg;

    `PTC_ASSERT(a_take_fills_first, aclk, aresetn, s_valid && s_ready |=> v_reg[0])
    `PTC_ASSERT(a_mid_stage_holds, aclk, aresetn,
        v_reg[1] && !rdy[2] |=> v_reg[1] && $stable(m1_reg) && $stable(dsq_reg))

endmodule

>>> rtl/ptc_press.sv
// Eight-stage pressure polynomial pipeline with output register.
module ptc_press (
    input  logic               aclk,
    input  logic               aresetn,
    input  ptc_pkg::ptc_coef_t coef,
    input  logic               s_valid,
    output logic               s_ready,
    input  ptc_pkg::ptc_mid_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ptc_pkg::ptc_out_t  m_data
);
    import ptc_pkg::*;

    `include "assert_macros.svh"

    localparam int STAGES = 8;

    logic [STAGES-1:0]  v_reg;
    logic [STAGES:0]    rdy;
    logic [23:0]        u_reg [STAGES];
    logic signed [23:0] t_reg [STAGES];

    // stage 1
    logic signed [47:0] tsq_reg, tsq_next;
    logic signed [33:0] dd_reg, dd_next;
    logic [47:0]        uu_reg, uu_next;
    // stage 2
    logic signed [31:0] tt_reg, tt_next;
    logic signed [55:0] tttp_reg, tttp_next;
    logic signed [47:0] apart1_reg, apart_next;
    logic signed [39:0] c1_1_reg, c1_next;
    logic signed [58:0] de_reg, de_next;
    logic [55:0]        uuu_reg, uuu_next;
    // stage 3
    logic signed [39:0] ttt_reg, ttt_next;
    logic signed [39:0] p7tt_reg, p7tt_next;
    logic signed [39:0] p3tt_reg, p3tt_next;
    logic signed [41:0] des_reg, des_next;
    logic signed [56:0] f1_reg, f1_next;
    logic signed [47:0] apart2_reg;
    logic signed [39:0] c1_2_reg;
    // stage 4
    logic signed [47:0] p8ttt_reg, p8ttt_next;
    logic signed [47:0] p4ttt_reg, p4ttt_next;
    logic signed [47:0] aacc_reg, aacc_next;
    logic signed [39:0] cacc_reg, cacc_next;
    logic [43:0]        elo_reg, elo_next;
    logic signed [46:0] ehi_reg, ehi_next;
    logic signed [39:0] f3_reg, f_next;
    // stage 5
    logic signed [47:0] a_reg, a_next;
    logic signed [39:0] c_reg, c_next;
    logic signed [44:0] e_reg, e_next;
    logic signed [39:0] f4_reg;
    // stage 6
    logic [43:0]        blo_reg, blo_next;
    logic signed [44:0] bhi_reg, bhi_next;
    logic signed [49:0] s1_5_reg, s1_next;
    // stage 7
    logic signed [49:0] b_reg, b_next;
    logic signed [49:0] s1_6_reg;
    // stage 8
    logic [25:0]        p_reg, p_next;

    always_comb begin
        rdy[STAGES] = m_ready;
        for (int i = STAGES - 1; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    always_comb begin
        logic signed [33:0] p9_w;
        logic signed [16:0] p1m_w;
        logic signed [16:0] p2m_w;
        logic signed [40:0] pr2_w;
        logic signed [39:0] p1_w;
        logic signed [67:0] ehi_w;
        logic signed [67:0] esum_w;
        logic signed [65:0] bhi_w;
        logic signed [65:0] bsum_w;
        logic signed [51:0] tot_w;
        logic signed [35:0] pr_w;

        // powers of T, the u^2 coefficient and u^2
        tsq_next = s_data.t * s_data.t;
        p9_w     = coef.p9;
        dd_next  = (p9_w <<< 16) + $signed(coef.p10) * s_data.t;
        uu_next  = s_data.u * s_data.u;

        tt_next    = $signed(tsq_reg[47:16]);
        tttp_next  = $signed(tsq_reg[47:16]) * t_reg[0];
        apart_next = $signed({5'b00000, coef.p5, 27'd0})
                   + (($signed({1'b0, coef.p6}) * t_reg[0]) <<< 2);
        p1m_w      = $signed(coef.p1) - 17'sd16384;
        p2m_w      = $signed(coef.p2) - 17'sd16384;
        pr2_w      = p2m_w * t_reg[0];
        p1_w       = p1m_w;
        c1_next    = (p1_w <<< 20) + $signed(pr2_w[40:5]);
        de_next    = dd_reg * $signed({1'b0, u_reg[0]});
        uuu_next   = uu_reg[47:16] * u_reg[0];

        ttt_next  = $signed(tttp_reg[55:16]);
        p7tt_next = $signed(coef.p7) * tt_reg;
        p3tt_next = $signed(coef.p3) * tt_reg;
        des_next  = $signed(de_reg[58:17]);
        f1_next   = $signed({1'b0, uuu_reg[55:8]}) * $signed(coef.p11);

        p8ttt_next = $signed(coef.p8) * ttt_reg;
        p4ttt_next = $signed(coef.p4) * ttt_reg;
        aacc_next  = apart2_reg + p7tt_reg;
        cacc_next  = c1_2_reg + $signed(p3tt_reg[39:8]);
        // E product split into low and high halves of the shifted D*u
        elo_next   = des_reg[19:0] * u_reg[2];
        ehi_next   = $signed(des_reg[41:20]) * $signed({1'b0, u_reg[2]});
        f_next     = $signed(f1_reg[56:17]);

        a_next = aacc_reg + $signed(p8ttt_reg[47:7]);
        c_next = cacc_reg + $signed(p4ttt_reg[47:13]);
        ehi_w  = ehi_reg;
        esum_w = (ehi_w <<< 20) + $signed({24'd0, elo_reg});
        e_next = $signed(esum_w[67:23]);

        blo_next = u_reg[4] * c_reg[19:0];
        bhi_next = $signed({1'b0, u_reg[4]}) * $signed(c_reg[39:20]);
        s1_next  = a_reg + e_reg + f4_reg;

        bhi_w  = bhi_reg;
        bsum_w = (bhi_w <<< 20) + $signed({22'd0, blo_reg});
        b_next = $signed(bsum_w[65:16]);

        tot_w = b_reg + s1_6_reg + 52'sd32768;
        pr_w  = $signed(tot_w[51:16]);
        if (pr_w < 36'sd0) begin
            p_next = '0;
        end else if (pr_w > $signed({10'd0, PRESS_MAX})) begin
            p_next = PRESS_MAX;
        end else begin
            p_next = pr_w[25:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            u_reg[0] <= s_data.u;
            t_reg[0] <= s_data.t;
        end
        for (int i = 1; i < STAGES; i++) begin
            if (rdy[i]) begin
                u_reg[i] <= u_reg[i-1];
                t_reg[i] <= t_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            tsq_reg <= tsq_next;
            dd_reg  <= dd_next;
            uu_reg  <= uu_next;
        end
        if (rdy[1]) begin
            tt_reg     <= tt_next;
            tttp_reg   <= tttp_next;
            apart1_reg <= apart_next;
            c1_1_reg   <= c1_next;
            de_reg     <= de_next;
            uuu_reg    <= uuu_next;
        end
        if (rdy[2]) begin
            ttt_reg    <= ttt_next;
            p7tt_reg   <= p7tt_next;
            p3tt_reg   <= p3tt_next;
            des_reg    <= des_next;
            f1_reg     <= f1_next;
            apart2_reg <= apart1_reg;
            c1_2_reg   <= c1_1_reg;
        end
        if (rdy[3]) begin
            p8ttt_reg <= p8ttt_next;
            p4ttt_reg <= p4ttt_next;
            aacc_reg  <= aacc_next;
            cacc_reg  <= cacc_next;
            elo_reg   <= elo_next;
            ehi_reg   <= ehi_next;
            f3_reg    <= f_next;
        end
        if (rdy[4]) begin
            a_reg  <= a_next;
            c_reg  <= c_next;
            e_reg  <= e_next;
            f4_reg <= f3_reg;
        end
        if (rdy[5]) begin
            blo_reg  <= blo_next;
            bhi_reg  <= bhi_next;
            s1_5_reg <= s1_next;
        end
        if (rdy[6]) begin
            b_reg    <= b_next;
            s1_6_reg <= s1_5_reg;
        end
        if (rdy[7]) begin
            p_reg <= p_next;
        end
    end

    assign s_ready                = rdy[0];
    assign m_valid                = v_reg[STAGES-1];
    assign m_data.pressure_out    = p_reg;
    assign m_data.temperature_out = t_reg[STAGES-1];

    `PTC_ASSERT(a_split_stage_holds, aclk, aresetn,
        v_reg[3] && !rdy[4] |=> v_reg[3] && $stable(elo_reg) && $stable(ehi_reg))
    `PTC_ASSERT(a_bubble_fills, aclk, aresetn,
        v_reg[5] && !v_reg[6] |=> v_reg[6])

endmodule

>>> rtl/pressure_temperature_compensation.sv
// Top level: calibration registers, temperature pipe and pressure pipe.
//
//  channel  ports                           carries
//  s_       s_valid s_ready s_data          raw_pressure, raw_temperature
//  m_       m_valid m_ready m_data          pressure_out, temperature_out
//  cfg_     cfg_we cfg_index cfg_wdata      calibration and clamp registers
//
// One transfer per cycle in and out while m_ready is high; 4 temperature
// and 8 pressure stages, the last one being the output register.
// Every stage has its own valid bit and moves when the one after it is
// empty or moving, so bubbles close up under an output stall.
// aresetn is synchronous; it empties the pipe and loads the register resets.
module pressure_temperature_compensation (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ptc_pkg::ptc_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ptc_pkg::ptc_out_t              m_data,
    input  logic                           cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ptc_pkg::*;

    ptc_coef_t coef;
    ptc_mid_t  mid_data;
    logic      mid_valid;
    logic      mid_ready;

    ptc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .coef      (coef)
    );

    ptc_temp u_temp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .coef    (coef),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (mid_valid),
        .m_ready (mid_ready),
        .m_data  (mid_data)
    );

    ptc_press u_press (
        .aclk    (aclk),
        .aresetn (aresetn),
        .coef    (coef),
        .s_valid (mid_valid),
        .s_ready (mid_ready),
        .s_data  (mid_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
